// File: rtl/atan2_octant_lookup_defines.svh
// Assertion macros for the atan2 octant lookup pipeline.
// Included by the top level; expects i_clk and i_rst_n in scope.
`ifndef ATAN2_OCTANT_LOOKUP_DEFINES_SVH
`define ATAN2_OCTANT_LOOKUP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define ATL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("atan2_octant_lookup: same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define ATL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("atan2_octant_lookup: next-cycle check failed");

`endif

// File: rtl/atl_pkg.sv
// Shared constants, pipeline payload type and arctangent ROM for the atan2 lookup.
// No dependencies; imported by every module of the block.
package atl_pkg;

    // Table size; must be a power of two
    localparam int ATAN_ENTRIES = 256;
    localparam int ATAN_LOG     = $clog2(ATAN_ENTRIES);
    localparam int MAG_W        = 16;
    localparam int ROM_W        = 8;
    localparam int ANG_W        = 10;
    localparam int OCT_STEPS    = 128;

    // Angle landmarks on the 1024-step circle
    localparam logic [ROM_W-1:0] OCT_TOP      = ROM_W'(OCT_STEPS);
    localparam logic [ANG_W-1:0] QUARTER_TURN = ANG_W'(256);
    localparam logic [ANG_W-1:0] HALF_TURN    = ANG_W'(512);

    // Fixed-point constants for building the table
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef logic [ROM_W-1:0] t_rom [ATAN_ENTRIES];

    // Payload carried through the divider stages
    typedef struct packed {
        logic [MAG_W-1:0]    num;
        logic [MAG_W-1:0]    den;
        logic [MAG_W-1:0]    rem;
        logic [ATAN_LOG-1:0] quot;
        logic                nx;
        logic                ny;
        logic                swap;
        logic                eq;
        logic                zero;
    } t_div;

    function automatic logic [63:0] mul_q30(logic [63:0] a, logic [63:0] b);
        return (a * b) >> 30;
    endfunction

    // Entry i counts the steps k whose tangent threshold is at or below i/ATAN_ENTRIES.
    // Threshold floor(s*2^32/c) <= t is tested as s*2^32 < (t+1)*c.
    function automatic t_rom atl_build_rom();
        logic [63:0] sv [OCT_STEPS];
        logic [63:0] cv [OCT_STEPS];
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] s;
        logic [63:0] ct;
        logic [63:0] c;
        logic [63:0] t;
        int          cnt;
        t_rom        rom;
        sv[0] = 64'd0;
        cv[0] = 64'd1;
        for (int k = 1; k < OCT_STEPS; k++) begin
            x  = (64'(k) * PI_Q30) >> 9;
            x2 = mul_q30(x, x);
            st = x;
            s  = x;
            ct = ONE_Q30;
            c  = ONE_Q30;
            for (int n = 1; n <= 8; n++) begin
                st = mul_q30(st, x2) / 64'((2 * n) * (2 * n + 1));
                ct = mul_q30(ct, x2) / 64'((2 * n - 1) * (2 * n));
                if ((n & 1) != 0) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            if (c == 64'd0) begin
                c = 64'd1;
            end
            sv[k] = s;
            cv[k] = c;
        end
        for (int i = 0; i < ATAN_ENTRIES; i++) begin
            t   = (64'(i) << 32) / ATAN_ENTRIES;
            cnt = 0;
            for (int k = 1; k < OCT_STEPS; k++) begin
                if ((sv[k] << 32) < ((t + 64'd1) * cv[k])) begin
                    cnt++;
                end
            end
            rom[i] = ROM_W'(cnt);
        end
        return rom;
    endfunction

    localparam t_rom ATL_ROM = atl_build_rom();

endpackage

// File: rtl/atan2_octant_lookup.sv
// atan2_octant_lookup: angle of a signed (dy, dx) vector on a 1024-step circle.
// Stages: two front stages, one divider stage per quotient bit,
// a ROM stage and an output register.
// Throughput: one item per cycle; each stage holds or advances on its own ready.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
`include "atan2_octant_lookup_defines.svh"

module atan2_octant_lookup
    import atl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [MAG_W-1:0] i_delta_y,
    input  logic signed [MAG_W-1:0] i_delta_x,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [ANG_W-1:0]        o_angle
);

    logic w_in_ready;
    logic w_v   [ATAN_LOG+1];
    logic w_rdy [ATAN_LOG+1];
    t_div w_d   [ATAN_LOG+1];

    assign o_stall = !w_in_ready;

    // Magnitudes and ordering
    atl_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (w_in_ready),
        .i_delta_y (i_delta_y),
        .i_delta_x (i_delta_x),
        .o_valid   (w_v[0]),
        .i_ready   (w_rdy[0]),
        .o_data    (w_d[0])
    );

    // Divider, one quotient bit per stage
    for (genvar k = 0; k < ATAN_LOG; k++) begin : g_div
        atl_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k]),
            .o_ready (w_rdy[k]),
            .i_data  (w_d[k]),
            .o_valid (w_v[k+1]),
            .i_ready (w_rdy[k+1]),
            .o_data  (w_d[k+1])
        );
    end

    // ROM and quadrant placement
    atl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[ATAN_LOG]),
        .o_ready (w_rdy[ATAN_LOG]),
        .i_data  (w_d[ATAN_LOG]),
        .o_valid (o_valid),
        .i_ready (!i_stall),
        .o_angle (o_angle)
    );

    // Checks
    `ATL_ASSERT_IMP(a_den_nonzero, w_v[0] && !w_d[0].zero, w_d[0].den != '0)
    `ATL_ASSERT_IMP(a_num_below_den, w_v[0] && !w_d[0].eq, w_d[0].num < w_d[0].den)
    `ATL_ASSERT_IMP(a_rem_bounded, w_v[ATAN_LOG] && !w_d[ATAN_LOG].eq, w_d[ATAN_LOG].rem < w_d[ATAN_LOG].den)
    `ATL_ASSERT_IMP(a_free_flow, !i_stall, !o_stall)
    `ATL_ASSERT_NXT(a_div_hold, w_v[ATAN_LOG] && !w_rdy[ATAN_LOG], w_v[ATAN_LOG] && $stable(w_d[ATAN_LOG]))

endmodule

// File: rtl/atl_front.sv
// Front end: magnitudes of both components, then ordering into numerator/denominator.
// Two register stages; uses atl_pkg.
module atl_front
    import atl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [MAG_W-1:0] i_delta_y,
    input  logic signed [MAG_W-1:0] i_delta_x,
    output logic                    o_valid,
    input  logic                    i_ready,
    output t_div                    o_data
);

    logic             r_a_valid;
    logic [MAG_W-1:0] r_ay;
    logic [MAG_W-1:0] r_ax;
    logic             r_ny;
    logic             r_nx;
    logic [MAG_W-1:0] n_ay;
    logic [MAG_W-1:0] n_ax;
    logic             a_ready;

    logic             r_b_valid;
    t_div             r_b;
    t_div             n_b;
    logic             b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;

    // Magnitudes; -32768 maps to 0x8000 unsigned
    assign n_ay = i_delta_y[MAG_W-1] ? (~$unsigned(i_delta_y) + MAG_W'(1)) : $unsigned(i_delta_y);
    assign n_ax = i_delta_x[MAG_W-1] ? (~$unsigned(i_delta_x) + MAG_W'(1)) : $unsigned(i_delta_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_ay <= n_ay;
            r_ax <= n_ax;
            r_ny <= i_delta_y[MAG_W-1];
            r_nx <= i_delta_x[MAG_W-1];
        end
    end

    // Smaller magnitude over larger; the divider starts with rem = num
    always_comb begin
        n_b.swap = r_ay > r_ax;
        n_b.eq   = r_ay == r_ax;
        n_b.zero = (r_ay == '0) && (r_ax == '0);
        n_b.num  = n_b.swap ? r_ax : r_ay;
        n_b.den  = n_b.swap ? r_ay : r_ax;
        n_b.rem  = n_b.num;
        n_b.quot = '0;
        n_b.nx   = r_nx;
        n_b.ny   = r_ny;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b;

endmodule

// File: rtl/atl_div_step.sv
// One restoring-division stage: produces one quotient bit per register stage.
// Uses atl_pkg; chained ATAN_LOG times by the top level.
module atl_div_step
    import atl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_div i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_div o_data
);

    logic           r_valid;
    t_div           r_data;
    t_div           n_data;
    logic [MAG_W:0] rem2;
    logic           ge;

    assign o_ready = !r_valid || i_ready;

    // Shift remainder, trial subtract; rem < den keeps rem2 within MAG_W+1 bits
    always_comb begin
        rem2        = {i_data.rem, 1'b0};
        ge          = rem2 >= {1'b0, i_data.den};
        n_data      = i_data;
        n_data.rem  = ge ? MAG_W'(rem2 - {1'b0, i_data.den}) : rem2[MAG_W-1:0];
        n_data.quot = (i_data.quot << 1) | ATAN_LOG'(ge);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/atl_back.sv
// Back end: ROM read of the octant angle, then mirror and quadrant placement.
// Two register stages; uses atl_pkg (ATL_ROM, angle constants).
module atl_back
    import atl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  t_div             i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ANG_W-1:0] o_angle
);

    logic             r_r_valid;
    logic [ROM_W-1:0] r_e;
    logic             r_nx;
    logic             r_ny;
    logic             r_swap;
    logic             r_zero;
    logic             rom_ready;

    logic             r_o_valid;
    logic [ANG_W-1:0] r_angle;
    logic [ANG_W-1:0] n_angle;
    logic [ANG_W-1:0] base;
    logic             out_ready;

    assign out_ready = !r_o_valid || i_ready;
    assign rom_ready = !r_r_valid || out_ready;
    assign o_ready   = rom_ready;

    // ROM stage; equal magnitudes skip the ROM and take OCT_TOP
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (rom_ready) begin
            r_r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rom_ready && i_valid) begin
            r_e    <= i_data.eq ? OCT_TOP : ATL_ROM[i_data.quot];
            r_nx   <= i_data.nx;
            r_ny   <= i_data.ny;
            r_swap <= i_data.swap;
            r_zero <= i_data.zero;
        end
    end

    // Zero maps to 0; else mirror about 128 if steep, then quadrant (mod 1024)
    always_comb begin
        base = r_swap ? (QUARTER_TURN - ANG_W'(r_e)) : ANG_W'(r_e);
        if (r_zero) begin
            n_angle = '0;
        end else if (!r_nx && !r_ny) begin
            n_angle = base;
        end else if (r_nx && !r_ny) begin
            n_angle = HALF_TURN - base;
        end else if (r_nx && r_ny) begin
            n_angle = HALF_TURN + base;
        end else begin
            n_angle = ANG_W'(0) - base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_ready) begin
            r_o_valid <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_r_valid) begin
            r_angle <= n_angle;
        end
    end

    assign o_valid = r_o_valid;
    assign o_angle = r_angle;

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for atan2_octant_lookup: directed vectors, then random ones.
// Depends on atl_pkg and the atan2_octant_lookup RTL; holds its own angle predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import atl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 24;     // extra wait after the final drain
    localparam int RANDOM_ITEMS   = 430;
    localparam int NO_ANGLE       = -1;     // row angle is left to the predictor
    localparam int N_DIRECTED     = 25;

    typedef struct {
        int dy;
        int dx;
        int angle;
    } t_vec_row;

    typedef struct {
        int               dy;
        int               dx;
        logic [ANG_W-1:0] angle;
    } t_pending_angle;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid;
    logic                    o_stall;
    logic signed [MAG_W-1:0] i_delta_y;
    logic signed [MAG_W-1:0] i_delta_x;
    logic                    o_valid;
    logic                    i_stall;
    logic [ANG_W-1:0]        o_angle;

    // Octant arctangent steps, index 0..ATAN_ENTRIES
    logic [7:0]     atan_steps [0:ATAN_ENTRIES];
    t_pending_angle angle_q [$];
    int             n_sent = 0;
    int             n_checked = 0;
    int             n_mismatch = 0;
    int             idle_cycles = 0;
    bit             burst_mode = 1'b0;

    // Extremes, axes, diagonals, the full-turn wrap and the most negative input
    t_vec_row directed_rows [N_DIRECTED] = '{
        '{0, 0, 0},             '{0, 32767, 0},         '{32767, 0, 256},
        '{0, -32768, 512},      '{-32768, 0, 768},      '{-1, 32767, 0},
        '{-1, 1, 896},          '{1, 1, 128},           '{-1, -1, 640},
        '{1, -1, 384},          '{32767, 32767, 128},   '{-32768, -32768, 640},
        '{32767, -32768, NO_ANGLE},                     '{-32768, 32767, NO_ANGLE},
        '{0, 1, 0},             '{1, 0, 256},           '{0, -1, 512},
        '{-1, 0, 768},          '{-32768, -1, 768},     '{-1, -32768, 512},
        '{32767, -1, 256},      '{100, 3, NO_ANGLE},    '{3, 100, NO_ANGLE},
        '{-12345, 23456, NO_ANGLE},                     '{23456, -12345, NO_ANGLE}
    };

    atan2_octant_lookup dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_delta_y (i_delta_y),
        .i_delta_x (i_delta_x),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_angle   (o_angle)
    );

    always #6 i_clk = ~i_clk;

    // Step table: entry i counts the k in 1..128 with tan(k*pi/512) <= i/ATAN_ENTRIES,
    // tangents as Q32 values from Q30 series for sin and cos
    initial begin : build_atan_steps
        logic [63:0] tan_limit [0:OCT_STEPS];
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] st;
        logic [63:0] s;
        logic [63:0] ct;
        logic [63:0] c;
        int          cnt;
        tan_limit[0] = 64'd0;
        for (int k = 1; k < OCT_STEPS; k++) begin
            x  = (64'(k) * 64'd3373259426) >> 9;
            x2 = (x * x) >> 30;
            st = x;
            s  = x;
            ct = 64'd1 << 30;
            c  = 64'd1 << 30;
            for (int n = 1; n <= 8; n++) begin
                st = ((st * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
                ct = ((ct * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n & 1) != 0) begin
                    s = s - st;
                    c = c - ct;
                end else begin
                    s = s + st;
                    c = c + ct;
                end
            end
            if (c == 64'd0) begin
                c = 64'd1;
            end
            tan_limit[k] = (s << 32) / c;
        end
        tan_limit[OCT_STEPS] = 64'd1 << 32;
        for (int i = 0; i <= ATAN_ENTRIES; i++) begin
            cnt = 0;
            for (int k = 1; k <= OCT_STEPS; k++) begin
                if (tan_limit[k] * 64'(ATAN_ENTRIES) <= (64'(i) << 32)) begin
                    cnt++;
                end
            end
            atan_steps[i] = 8'(cnt);
        end
    end

    // Expected angle of one vector: octant lookup, mirror above 45 degrees, quadrant
    function automatic logic [ANG_W-1:0] vector_angle(input int dy, input int dx);
        int ay;
        int ax;
        int idx;
        int base;
        int ang;
        ay = (dy < 0) ? -dy : dy;
        ax = (dx < 0) ? -dx : dx;
        if (ax == 0 && ay == 0) begin
            return '0;
        end
        if (ax >= ay) begin
            idx = (ay * ATAN_ENTRIES) / ax;
            if (idx > ATAN_ENTRIES) begin
                idx = ATAN_ENTRIES;
            end
            base = int'(atan_steps[idx]);
        end else begin
            idx = (ax * ATAN_ENTRIES) / ay;
            if (idx > ATAN_ENTRIES) begin
                idx = ATAN_ENTRIES;
            end
            base = 256 - int'(atan_steps[idx]);
        end
        if (dx >= 0 && dy >= 0) begin
            ang = base;
        end else if (dx < 0 && dy >= 0) begin
            ang = 512 - base;
        end else if (dx < 0) begin
            ang = 512 + base;
        end else begin
            ang = 1024 - base;
        end
        // 1024 wraps to 0
        return ANG_W'(ang);
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 93) begin
            return $urandom_range(4, 9);
        end
        return $urandom_range(12, 40);
    endfunction

    // Present one vector, hold it until accepted, record its angle, then maybe pause
    task automatic send_vector(input int dy, input int dx, input int typed_angle);
        t_pending_angle p;
        int             gap;
        i_valid   <= 1'b1;
        i_delta_y <= MAG_W'(dy);
        i_delta_x <= MAG_W'(dx);
        do @(posedge i_clk); while (o_stall);
        p.dy    = dy;
        p.dx    = dx;
        p.angle = (typed_angle == NO_ANGLE) ? vector_angle(dy, dx) : ANG_W'(typed_angle);
        angle_q.push_back(p);
        n_sent++;
        gap = (burst_mode || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop sending until every outstanding angle has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (angle_q.size() != 0);
    endtask

    // Stimulus: reset, directed table, random vectors
    initial begin : stimulus
        int dy;
        int dx;
        int m;
        int kind;
        int edge_val;
        i_valid   <= 1'b0;
        i_delta_y <= '0;
        i_delta_x <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            send_vector(directed_rows[r].dy, directed_rows[r].dx, directed_rows[r].angle);
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                burst_mode = ($urandom_range(0, 2) == 0);
            end
            if (n == 150 || n == 300) begin
                drain_results();
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // full 16-bit range
                dy = $urandom_range(0, 65535) - 32768;
                dx = $urandom_range(0, 65535) - 32768;
            end else if (kind < 55) begin
                // small magnitudes, coarse quotients
                dy = $urandom_range(0, 128) - 64;
                dx = $urandom_range(0, 128) - 64;
            end else if (kind < 75) begin
                // close to a diagonal, where the octant swaps
                m  = $urandom_range(1, 32767);
                dy = m;
                dx = m + $urandom_range(0, 8) - 4;
                if (dx > 32767) begin
                    dx = 32767;
                end
                if ($urandom_range(0, 1) == 1) begin
                    dy = -dy;
                end
                if ($urandom_range(0, 1) == 1) begin
                    dx = -dx;
                end
            end else if (kind < 85) begin
                // one component on an axis value or an extreme
                case ($urandom_range(0, 4))
                    0: edge_val = 0;
                    1: edge_val = 1;
                    2: edge_val = -1;
                    3: edge_val = 32767;
                    default: edge_val = -32768;
                endcase
                m = $urandom_range(0, 65535) - 32768;
                if ($urandom_range(0, 1) == 1) begin
                    dy = edge_val;
                    dx = m;
                end else begin
                    dy = m;
                    dx = edge_val;
                end
            end else begin
                // both magnitudes large
                dy = ($urandom_range(0, 1) == 1) ? int'($urandom_range(16384, 32767))
                                                 : -int'($urandom_range(16384, 32768));
                dx = ($urandom_range(0, 1) == 1) ? int'($urandom_range(16384, 32767))
                                                 : -int'($urandom_range(16384, 32768));
            end
            send_vector(dy, dx, NO_ANGLE);
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Run covered %0d vectors (%0d directed, rest random: full range, small,",
                 n_sent, N_DIRECTED);
        $display("near-diagonal, axis and large magnitudes); %0d angles checked, %0d bad.",
                 n_checked, n_mismatch);
        if (n_mismatch == 0 && angle_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Output stall: random runs and stalls, with stretches of no stalling
    initial begin : drive_stall
        i_stall <= 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 5) == 0) begin
                i_stall <= 1'b0;
                repeat ($urandom_range(30, 80)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                i_stall <= 1'b1;
                repeat (pause_len()) @(posedge i_clk);
            end
        end
    end

    // Compare each accepted angle with the oldest expectation; watchdog on no progress
    always @(posedge i_clk) begin : check_angles
        t_pending_angle want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (angle_q.size() == 0) begin
                    $display("%0t: unexpected angle: expected none, actual %0d",
                             $time, o_angle);
                    n_mismatch++;
                end else begin
                    want = angle_q.pop_front();
                    n_checked++;
                    if (o_angle !== want.angle) begin
                        $display("%0t: angle for (dy %0d, dx %0d): expected %0d, actual %0d",
                                 $time, want.dy, want.dx, want.angle, o_angle);
                        n_mismatch++;
                    end
                end
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: watchdog: no item moved for %0d cycles, %0d angles outstanding",
                         $time, idle_cycles, angle_q.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule
